### design/icmp_probe_reply_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// ICMP probe reply matcher assertion macros
// Shared concurrent assertion forms used at the end of the design modules.
// ----------------------------------------------------------------------------
`ifndef ICMP_PROBE_REPLY_MATCHER_TOP_DEFINES_SVH
`define ICMP_PROBE_REPLY_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IPRM_ASSERT_SAME(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("iprm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IPRM_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("iprm assertion failed");

`endif

### design/iprm_pkg.sv
// ----------------------------------------------------------------------------
// ICMP probe reply matcher package
// Shared constants, the parser result type and the ttl round check.
// ----------------------------------------------------------------------------
package iprm_pkg;

  localparam int PROBES_PER_TTL = 3;

  localparam int OWN_ID_W = 20;
  localparam int TTL_W    = 8;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 1;
  // Wide enough for the 12-bit round field and PROBES_PER_TTL times any ttl.
  localparam int RND_W    = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_TTL = 1'b1;

  localparam logic [7:0] KIND_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] KIND_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] KIND_TIME_EXCEEDED = 8'd11;

  typedef struct packed {
    logic done;
    logic is_match;
  } iprm_result_t;

  // The round (rnd / PROBES_PER_TTL) + 1 equals ttl exactly when rnd lies in
  // the window of PROBES_PER_TTL values that starts at PROBES_PER_TTL * (ttl - 1).
  function automatic logic round_hit(input logic [11:0] rnd, input logic [TTL_W-1:0] ttl);
    logic [RND_W-1:0] base;
    logic [RND_W-1:0] lo;
    logic [RND_W-1:0] hi;
    logic [RND_W-1:0] rnd_x;
    base  = RND_W'(ttl) - RND_W'(1);
    lo    = base * RND_W'(PROBES_PER_TTL);
    hi    = lo + RND_W'(PROBES_PER_TTL);
    rnd_x = RND_W'(rnd);
    return (ttl != '0) && (rnd_x >= lo) && (rnd_x < hi);
  endfunction

endpackage

### design/iprm_parser.sv
// ----------------------------------------------------------------------------
// ICMP probe reply matcher byte parser
// Walks the IP and ICMP headers one byte per transaction, descending into
// quoted packets of time exceeded messages, and judges echo identifiers.
// ----------------------------------------------------------------------------
`include "icmp_probe_reply_matcher_top_defines.svh"

module iprm_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    packet_byte,
  input  logic                          last_byte,
  input  logic [iprm_pkg::OWN_ID_W-1:0] own_id,
  input  logic [iprm_pkg::TTL_W-1:0]    probe_ttl,
  output iprm_pkg::iprm_result_t        result
);
  import iprm_pkg::*;

  localparam logic [1:0] PH_IP_START = 2'd0;
  localparam logic [1:0] PH_IP_SKIP  = 2'd1;
  localparam logic [1:0] PH_ICMP     = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [5:0]  byte_offset, byte_offset_next;
  logic [5:0]  header_length, header_length_next;
  logic [7:0]  icmp_kind, icmp_kind_next;
  logic [15:0] probe_ident, probe_ident_next;
  logic [7:0]  seq_high, seq_high_next;
  logic        verdict, verdict_next;

  logic [5:0]  offset_inc;
  logic        kind_known;
  logic        judge;

  assign offset_inc = byte_offset + 6'd1;
  assign kind_known = (packet_byte == KIND_TIME_EXCEEDED) ||
                      (packet_byte == KIND_ECHO_REQUEST) ||
                      (packet_byte == KIND_ECHO_REPLY);
  assign judge = ({packet_byte[3:0], probe_ident} == own_id) &&
                 round_hit({seq_high, packet_byte[7:4]}, probe_ttl);

  always_comb begin
    phase_next         = phase;
    byte_offset_next   = byte_offset;
    header_length_next = header_length;
    icmp_kind_next     = icmp_kind;
    probe_ident_next   = probe_ident;
    seq_high_next      = seq_high;
    verdict_next       = verdict;
    unique case (phase)
      PH_IP_START: begin
        if (packet_byte[3:0] < 4'd5) begin
          verdict_next = 1'b0;
          phase_next   = PH_DONE;
        end else begin
          header_length_next = {packet_byte[3:0], 2'b00};
          byte_offset_next   = 6'd1;
          phase_next         = PH_IP_SKIP;
        end
      end
      PH_IP_SKIP: begin
        byte_offset_next = offset_inc;
        if (offset_inc >= header_length) begin
          byte_offset_next = 6'd0;
          phase_next       = PH_ICMP;
        end
      end
      PH_ICMP: begin
        byte_offset_next = offset_inc;
        case (byte_offset)
          6'd0: begin
            icmp_kind_next = packet_byte;
            if (!kind_known) begin
              byte_offset_next = byte_offset;
              verdict_next     = 1'b0;
              phase_next       = PH_DONE;
            end
          end
          6'd4: probe_ident_next[15:8] = packet_byte;
          6'd5: probe_ident_next[7:0]  = packet_byte;
          6'd6: seq_high_next          = packet_byte;
          6'd7: begin
            byte_offset_next = byte_offset;
            if (icmp_kind == KIND_TIME_EXCEEDED) begin
              byte_offset_next = 6'd0;
              phase_next       = PH_IP_START;
            end else begin
              verdict_next = judge;
              phase_next   = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  assign result.done     = take && last_byte;
  assign result.is_match = (phase_next == PH_DONE) && verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IP_START;
      byte_offset <= 6'd0;
      verdict     <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        phase       <= PH_IP_START;
        byte_offset <= 6'd0;
        verdict     <= 1'b0;
      end else begin
        phase       <= phase_next;
        byte_offset <= byte_offset_next;
        verdict     <= verdict_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      header_length <= header_length_next;
      icmp_kind     <= icmp_kind_next;
      probe_ident   <= probe_ident_next;
      seq_high      <= seq_high_next;
    end
  end

  `IPRM_ASSERT_NEXT(a_restart_after_last, clk, rst, take && last_byte,
                    phase == PH_IP_START && byte_offset == 6'd0)
  `IPRM_ASSERT_SAME(a_skip_header_len, clk, rst, phase == PH_IP_SKIP,
                    header_length >= 6'd20)
  `IPRM_ASSERT_SAME(a_icmp_offset_range, clk, rst, phase == PH_ICMP,
                    byte_offset <= 6'd7)

endmodule

### design/icmp_probe_reply_matcher_top.sv
// ----------------------------------------------------------------------------
// ICMP probe reply matcher
// Receives an IPv4 packet one byte per input transaction and produces one
// match verdict per packet for replies to this host's ttl probes.
// ----------------------------------------------------------------------------
// The input channel carries packet_byte and last_byte under in_valid and
// in_ready; one byte is taken per transaction, in wire order. The output
// channel carries is_match under out_valid and out_ready, with one
// transaction per packet, issued for the byte flagged by last_byte.
// The parser state is updated in the cycle the byte is taken, so the input
// sustains one transaction per clock while in_ready is high. The verdict sits
// in the output register in the cycle after the last byte is taken.
// The output register also decouples the two sides: while a verdict waits,
// bytes keep flowing; only a second verdict arriving while the first is still
// stalled holds in_ready low until out_ready frees the register.
// Synchronous reset returns the parser to the start of an IP header, empties
// the output register, and sets own_id to 0 and probe_ttl to 1. Configuration
// writes through cfg_we, cfg_index and cfg_wdata take effect in the next cycle and
// are meant to happen while no packet is in progress.
// ----------------------------------------------------------------------------
`include "icmp_probe_reply_matcher_top_defines.svh"

module icmp_probe_reply_matcher_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     packet_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           is_match,
  input  logic                           cfg_we,
  input  logic [iprm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iprm_pkg::CFG_W-1:0]     cfg_wdata
);
  import iprm_pkg::*;

  logic [OWN_ID_W-1:0] own_id;
  logic [TTL_W-1:0]    probe_ttl;
  logic                take;
  iprm_result_t        result;

  assign in_ready = !out_valid || out_ready || !last_byte;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id    <= '0;
      probe_ttl <= TTL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ID:    own_id    <= cfg_wdata[OWN_ID_W-1:0];
        CFG_PROBE_TTL: probe_ttl <= cfg_wdata[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  iprm_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .packet_byte (packet_byte),
    .last_byte   (last_byte),
    .own_id      (own_id),
    .probe_ttl   (probe_ttl),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.done) begin
      is_match <= result.is_match;
    end
  end

  `IPRM_ASSERT_NEXT(a_last_gives_result, clk, rst, take && last_byte, out_valid)
  `IPRM_ASSERT_NEXT(a_no_spurious_result, clk, rst,
                    take && !last_byte && (!out_valid || out_ready), !out_valid)
  `IPRM_ASSERT_SAME(a_result_from_last, clk, rst, $rose(out_valid),
                    $past(in_valid && in_ready && last_byte))

endmodule
